// ===== rtl/rlfp_pkg.sv =====
`default_nettype none

package rlfp_pkg;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        REG_REVERSE_THRESHOLD = 2'd0,
        REG_WRAP_THRESHOLD    = 2'd1,
        REG_FAST_STEP         = 2'd2
    } reg_index_t;

    // Item kinds carried on the input side.
    typedef enum logic {
        OP_FRAME_STEP = 1'b0,
        OP_PWM_SLOT   = 1'b1
    } op_t;

    // Display modes.
    typedef enum logic [1:0] {
        MODE_TABLE  = 2'd0,
        MODE_GREEN  = 2'd1,
        MODE_YELLOW = 2'd2,
        MODE_RED    = 2'd3
    } mode_t;

    localparam logic [7:0] REVERSE_THRESHOLD_RESET = 8'd150;
    localparam logic [7:0] WRAP_THRESHOLD_RESET    = 8'd245;
    localparam logic [6:0] FAST_STEP_RESET         = 7'd8;

    // Color table, one ramp bit per channel. Entries past the six colors are dark.
    localparam logic [7:0] TAB_RED   = 8'b0001_1001;
    localparam logic [7:0] TAB_GREEN = 8'b0010_1010;
    localparam logic [7:0] TAB_BLUE  = 8'b0011_0100;

    typedef struct packed {
        logic [7:0] reverse_threshold;
        logic [7:0] wrap_threshold;
        logic [6:0] fast_step;
    } cfg_t;

    typedef struct packed {
        op_t        op;
        logic       button_pressed;
        logic [7:0] pwm_phase;
    } item_t;

    typedef struct packed {
        logic [1:0] mode;
        logic [7:0] blue_level;
        logic [7:0] green_level;
        logic [7:0] red_level;
        logic [2:0] led_bits;
    } result_t;

endpackage

`default_nettype wire

// ===== rtl/rlfp_pwm.sv =====
`default_nettype none

// Slot comparator: a channel is lit while the phase is below both its level and the PWM period.
module rlfp_pwm #(
    parameter int PWM_PERIOD = 255
) (
    input  wire logic [7:0] pwm_phase,
    input  wire logic [7:0] red_level,
    input  wire logic [7:0] green_level,
    input  wire logic [7:0] blue_level,
    output logic      [2:0] led_bits
);

    localparam logic [8:0] PERIOD = 9'(PWM_PERIOD);

    logic in_period;

    assign in_period = ({1'b0, pwm_phase} < PERIOD);

    always_comb begin
        led_bits    = 3'b000;
        led_bits[2] = in_period && (pwm_phase < red_level);
        led_bits[1] = in_period && (pwm_phase < blue_level);
        led_bits[0] = in_period && (pwm_phase < green_level);
    end

endmodule

`default_nettype wire

// ===== rtl/rlfp_core.sv =====
`default_nettype none

// Fader state and the combinational update for one item.
module rlfp_core #(
    parameter int TABLE_ENTRIES = 6,
    parameter int PWM_PERIOD    = 255
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              item_fire,
    input  wire rlfp_pkg::item_t   item,
    input  wire rlfp_pkg::cfg_t    cfg,
    output rlfp_pkg::result_t      result
);

    localparam logic [3:0] ENTRIES = 4'(TABLE_ENTRIES);

    logic [7:0]      red_value_reg, green_value_reg, blue_value_reg;
    logic [7:0]      red_value_next, green_value_next, blue_value_next;
    logic [7:0]      red_step_reg, green_step_reg, blue_step_reg;
    logic [7:0]      red_step_next, green_step_next, blue_step_next;
    rlfp_pkg::mode_t mode_reg, mode_next;
    logic [2:0]      table_index_reg, table_index_next;
    logic            reload_pending_reg, reload_pending_next;
    logic            button_held_reg, button_held_next;

    logic [7:0] red_sum, green_sum, blue_sum;
    logic       wrap_hit, do_reload;
    logic [3:0] index_inc;
    logic [7:0] fast_ext;
    logic [2:0] led_bits;

    assign red_sum   = red_value_reg + red_step_reg;
    assign green_sum = green_value_reg + green_step_reg;
    assign blue_sum  = blue_value_reg + blue_step_reg;

    assign wrap_hit  = (red_sum > cfg.wrap_threshold) || (green_sum > cfg.wrap_threshold)
                    || (blue_sum > cfg.wrap_threshold);
    assign do_reload = reload_pending_reg || wrap_hit;
    assign index_inc = {1'b0, table_index_reg} + 4'd1;
    assign fast_ext  = {1'b0, cfg.fast_step};

    always_comb begin
        red_value_next      = red_value_reg;
        green_value_next    = green_value_reg;
        blue_value_next     = blue_value_reg;
        red_step_next       = red_step_reg;
        green_step_next     = green_step_reg;
        blue_step_next      = blue_step_reg;
        mode_next           = mode_reg;
        table_index_next    = table_index_reg;
        reload_pending_next = reload_pending_reg;
        button_held_next    = button_held_reg;

        if (item_fire && item.op == rlfp_pkg::OP_FRAME_STEP) begin
            red_value_next   = red_sum;
            green_value_next = green_sum;
            blue_value_next  = blue_sum;
            if (red_sum > cfg.reverse_threshold) begin
                red_step_next = 8'd0 - red_step_reg;
            end
            if (green_sum > cfg.reverse_threshold) begin
                green_step_next = 8'd0 - green_step_reg;
            end
            if (blue_sum > cfg.reverse_threshold) begin
                blue_step_next = 8'd0 - blue_step_reg;
            end

            // A reload uses the mode held before this frame's button sample.
            if (do_reload) begin
                red_value_next   = 8'd0;
                green_value_next = 8'd0;
                blue_value_next  = 8'd0;
                unique case (mode_reg)
                    rlfp_pkg::MODE_TABLE: begin
                        red_step_next   = {7'd0, rlfp_pkg::TAB_RED[table_index_reg]};
                        green_step_next = {7'd0, rlfp_pkg::TAB_GREEN[table_index_reg]};
                        blue_step_next  = {7'd0, rlfp_pkg::TAB_BLUE[table_index_reg]};
                    end
                    rlfp_pkg::MODE_GREEN: begin
                        red_step_next   = 8'd0;
                        green_step_next = fast_ext;
                        blue_step_next  = 8'd0;
                    end
                    rlfp_pkg::MODE_YELLOW: begin
                        red_step_next   = fast_ext;
                        green_step_next = fast_ext;
                        blue_step_next  = 8'd0;
                    end
                    rlfp_pkg::MODE_RED: begin
                        red_step_next   = fast_ext;
                        green_step_next = 8'd0;
                        blue_step_next  = 8'd0;
                    end
                    default: begin
                        red_step_next   = 8'd0;
                        green_step_next = 8'd0;
                        blue_step_next  = 8'd0;
                    end
                endcase
                table_index_next = (index_inc >= ENTRIES) ? 3'd0 : index_inc[2:0];
            end

            // Reload is requested again only by a button release.
            reload_pending_next = 1'b0;
            if (item.button_pressed) begin
                button_held_next = 1'b1;
            end else if (button_held_reg) begin
                button_held_next    = 1'b0;
                mode_next           = rlfp_pkg::mode_t'(mode_reg + 2'd1);
                reload_pending_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            red_value_reg      <= 8'd0;
            green_value_reg    <= 8'd0;
            blue_value_reg     <= 8'd0;
            red_step_reg       <= 8'd0;
            green_step_reg     <= 8'd0;
            blue_step_reg      <= 8'd0;
            mode_reg           <= rlfp_pkg::MODE_TABLE;
            table_index_reg    <= 3'd0;
            reload_pending_reg <= 1'b1;
            button_held_reg    <= 1'b0;
        end else begin
            red_value_reg      <= red_value_next;
            green_value_reg    <= green_value_next;
            blue_value_reg     <= blue_value_next;
            red_step_reg       <= red_step_next;
            green_step_reg     <= green_step_next;
            blue_step_reg      <= blue_step_next;
            mode_reg           <= mode_next;
            table_index_reg    <= table_index_next;
            reload_pending_reg <= reload_pending_next;
            button_held_reg    <= button_held_next;
        end
    end

    rlfp_pwm #(
        .PWM_PERIOD(PWM_PERIOD)
    ) u_pwm (
        .pwm_phase  (item.pwm_phase),
        .red_level  (red_value_reg),
        .green_level(green_value_reg),
        .blue_level (blue_value_reg),
        .led_bits   (led_bits)
    );

    // Frame steps report no LED bits; PWM slots leave the state untouched.
    always_comb begin
        result.led_bits    = (item.op == rlfp_pkg::OP_PWM_SLOT) ? led_bits : 3'b000;
        result.red_level   = red_value_next;
        result.green_level = green_value_next;
        result.blue_level  = blue_value_next;
        result.mode        = mode_next;
    end

endmodule

`default_nettype wire

// ===== rtl/rgb_led_fade_pwm.sv =====
`default_nettype none

// Three-channel RGB LED fader. Each input item is either a frame step
// (s_tuser low), which ramps the red, green and blue levels, reverses a
// ramp above the reverse threshold, reloads the ramps when a level passes
// the wrap threshold and samples the button to change the mode on release,
// or a PWM slot (s_tuser high), which compares its phase with the three
// levels and reports which LEDs are lit. Every item yields exactly one
// result item carrying the LED bits, the three levels after the item and
// the mode. The block takes one item per clock while results are taken: an
// input register feeds a single pass of add, compare and select logic that
// writes the state and the result register in the same cycle; the result
// register drives m_tvalid and m_tdata. While a result waits, the input
// register still takes one more item; s_tready then stays low until the
// waiting result is taken. The user must write thresholds and the fast step
// through the cfg_* port only while no item is in flight; the block does
// not enforce this.
module rgb_led_fade_pwm #(
    parameter int TABLE_ENTRIES = 6,
    parameter int PWM_PERIOD    = 255
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,

    // Input items.
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,   // [0] button_pressed, [8:1] pwm_phase, rest zero
    input  wire logic [0:0]  s_tuser,   // [0] op

    // Result items.
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [31:0] m_tdata,   // [2:0] led_bits, [10:3] red_level,
                                        // [18:11] green_level, [26:19] blue_level,
                                        // [28:27] mode, rest zero

    // Configuration writes.
    input  wire logic        cfg_wr_en,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [7:0]  cfg_wdata
);

    rlfp_pkg::cfg_t    cfg_reg;
    rlfp_pkg::item_t   item_reg;
    logic              item_valid_reg;
    rlfp_pkg::result_t result_reg;
    logic              result_valid_reg;
    rlfp_pkg::result_t result;
    logic              advance;
    logic              item_fire;

    // The working stage moves whenever the result register is free or drains.
    assign advance   = !result_valid_reg || m_tready;
    assign item_fire = item_valid_reg && advance;
    assign s_tready  = !item_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.reverse_threshold <= rlfp_pkg::REVERSE_THRESHOLD_RESET;
            cfg_reg.wrap_threshold    <= rlfp_pkg::WRAP_THRESHOLD_RESET;
            cfg_reg.fast_step         <= rlfp_pkg::FAST_STEP_RESET;
        end else if (cfg_wr_en) begin
            // Writes to an index past the register list are dropped.
            unique case (rlfp_pkg::reg_index_t'(cfg_index))
                rlfp_pkg::REG_REVERSE_THRESHOLD: cfg_reg.reverse_threshold <= cfg_wdata;
                rlfp_pkg::REG_WRAP_THRESHOLD:    cfg_reg.wrap_threshold    <= cfg_wdata;
                rlfp_pkg::REG_FAST_STEP:         cfg_reg.fast_step         <= cfg_wdata[6:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            item_valid_reg <= 1'b0;
        end else if (s_tready) begin
            item_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            item_reg.op             <= rlfp_pkg::op_t'(s_tuser[0]);
            item_reg.button_pressed <= s_tdata[0];
            item_reg.pwm_phase      <= s_tdata[8:1];
        end
    end

    rlfp_core #(
        .TABLE_ENTRIES(TABLE_ENTRIES),
        .PWM_PERIOD   (PWM_PERIOD)
    ) u_core (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .item_fire(item_fire),
        .item     (item_reg),
        .cfg      (cfg_reg),
        .result   (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            result_valid_reg <= 1'b0;
        end else if (advance) begin
            result_valid_reg <= item_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (item_fire) begin
            result_reg <= result;
        end
    end

    assign m_tvalid = result_valid_reg;
    assign m_tdata  = {3'd0, result_reg};

endmodule

`default_nettype wire
